// ===== design/hspj_pkg.sv =====
// ---------------------------------------------------------------------------
// hspj_pkg
// Shared widths, register indexes and payload types of the Halton subpixel
// jitter generator.
// ---------------------------------------------------------------------------
package hspj_pkg;

	// default sizes of the sequence counters and the jitter fraction
	localparam int COUNT_BITS_DEF = 31;
	localparam int FRAC_BITS_DEF  = 30;

	// fixed field widths
	localparam int OUT_W  = 31;
	localparam int JIT_W  = 32;
	localparam int SIZE_W = 14;

	// configuration port
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 3;
	localparam int REG_IDX_BIT = 2;
	localparam logic REG_VIEWPORT_WIDTH  = 1'b0;
	localparam logic REG_VIEWPORT_HEIGHT = 1'b1;

	// one frame tick
	typedef struct packed {
		logic restart;
	} frame_req_t;

	// one frame result
	typedef struct packed {
		logic [OUT_W-1:0]        x_numerator;
		logic [OUT_W-1:0]        x_denominator;
		logic [OUT_W-1:0]        y_numerator;
		logic [OUT_W-1:0]        y_denominator;
		logic signed [JIT_W-1:0] jitter_x;
		logic signed [JIT_W-1:0] jitter_y;
		logic                    wrapped;
	} frame_rsp_t;

	// status of a jitter unit
	typedef struct packed {
		logic busy;
		logic done;
	} jit_stat_t;

endpackage

// ===== design/hspj_stream_if.sv =====
// ---------------------------------------------------------------------------
// hspj_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface hspj_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/hspj_jitter.sv =====
// ---------------------------------------------------------------------------
// hspj_jitter
// Bit-serial jitter unit: round((2n - d) * 2^FRAC_BITS / (d * size)),
// saturated to 32 bits. Two chained restoring dividers, one bit per cycle.
// ---------------------------------------------------------------------------
module hspj_jitter #(
	parameter int COUNT_BITS = hspj_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = hspj_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [COUNT_BITS-1:0]             num,
	input  logic [COUNT_BITS-1:0]             den,
	input  logic [hspj_pkg::SIZE_W-1:0]       size,
	output hspj_pkg::jit_stat_t               stat,
	output logic signed [hspj_pkg::JIT_W-1:0] jitter
);
	import hspj_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int RW = (QW > 33) ? QW : 33;
	localparam int CW = $clog2(QW + 2);

	typedef enum logic [2:0] {
		J_IDLE,
		J_PREP,
		J_DIV,
		J_ROUND,
		J_SAT
	} jstate_t;

	jstate_t                 state_q;
	logic [CW-1:0]           cnt_q;
	logic                    done_q;

	logic [COUNT_BITS-1:0]   n_q;
	logic [COUNT_BITS-1:0]   d_q;
	logic [SIZE_W-1:0]       size_q;
	logic                    neg_q;
	logic [COUNT_BITS:0]     r_q;
	logic                    bit_q;
	logic [SIZE_W-1:0]       rem_q;
	logic [QW-1:0]           quo_q;
	logic [QW-1:0]           res_q;
	logic [JIT_W-1:0]        jit_q;

	logic [COUNT_BITS:0]     two_n;
	logic [COUNT_BITS:0]     d_ext;
	logic                    is_pos;
	logic [COUNT_BITS:0]     mag;
	logic [COUNT_BITS+1:0]   r_sh;
	logic                    r_ge;
	logic [COUNT_BITS+1:0]   r_diff;
	logic [SIZE_W:0]         t_val;
	logic                    t_ge;
	logic [SIZE_W:0]         t_diff;
	logic [QW:0]             rnd_sum;
	logic [RW-1:0]           res_w;
	logic [RW-1:0]           lim_w;
	logic [JIT_W-1:0]        mag32;

	// |2n - d| and its sign
	assign two_n  = {n_q, 1'b0};
	assign d_ext  = {1'b0, d_q};
	assign is_pos = (two_n >= d_ext);
	assign mag    = is_pos ? (two_n - d_ext) : (d_ext - two_n);

	// fraction divider step: one quotient bit of mag * 2^QW / d
	assign r_sh   = {r_q, 1'b0};
	assign r_ge   = (r_sh >= {2'b00, d_q});
	assign r_diff = r_sh - {2'b00, d_q};

	// size divider step, fed by the fraction bit registered in the cycle before
	assign t_val  = {rem_q, bit_q};
	assign t_ge   = (t_val >= {1'b0, size_q});
	assign t_diff = t_val - {1'b0, size_q};

	// round half up, then clamp to the signed 32 bit range
	assign rnd_sum = {1'b0, quo_q} + (QW+1)'(1);
	assign res_w   = RW'(res_q);
	assign lim_w   = neg_q ? RW'(33'h0_8000_0000) : RW'(33'h0_7FFF_FFFF);
	assign mag32   = (res_w > lim_w) ? lim_w[JIT_W-1:0] : res_w[JIT_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= J_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				J_IDLE: begin
					if (start) begin
						state_q <= J_PREP;
					end
				end
				J_PREP: begin
					cnt_q   <= '0;
					state_q <= J_DIV;
				end
				J_DIV: begin
					if (cnt_q == CW'(QW)) begin
						state_q <= J_ROUND;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				J_ROUND: begin
					state_q <= J_SAT;
				end
				J_SAT: begin
					done_q  <= 1'b1;
					state_q <= J_IDLE;
				end
				default: begin
					state_q <= J_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			J_IDLE: begin
				if (start) begin
					n_q    <= num;
					d_q    <= den;
					size_q <= (size == '0) ? SIZE_W'(1) : size;
				end
			end
			J_PREP: begin
				neg_q <= !is_pos;
				r_q   <= mag;
				bit_q <= 1'b0;
				rem_q <= '0;
				quo_q <= '0;
			end
			J_DIV: begin
				// both dividers run every cycle; the extra leading zero shifts out
				r_q   <= r_ge ? r_diff[COUNT_BITS:0] : r_sh[COUNT_BITS:0];
				bit_q <= r_ge;
				rem_q <= t_ge ? t_diff[SIZE_W-1:0] : t_val[SIZE_W-1:0];
				quo_q <= {quo_q[QW-2:0], t_ge};
			end
			J_ROUND: begin
				res_q <= rnd_sum[QW:1];
			end
			J_SAT: begin
				jit_q <= neg_q ? (JIT_W'(0) - mag32) : mag32;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != J_IDLE);
	assign stat.done = done_q;
	assign jitter    = jit_q;

endmodule

// ===== design/halton_subpixel_jitter_generator.sv =====
// ---------------------------------------------------------------------------
// halton_subpixel_jitter_generator
// Frame-rate Halton (2,3) subpixel jitter source with raw fractions.
// ---------------------------------------------------------------------------
// Each transfer on req is one frame tick: both Halton sequences (base 2 for
// x, base 3 for y) advance once and one result goes out on rsp with the new
// fractions and the jitters (2*frac-1)/size in signed Q1.FRAC_BITS. The
// incremental update searches one power of the base per cycle, for at most
// COUNT_BITS-2 search steps; the two jitter units then produce one quotient
// bit per cycle. One frame is in flight at a time; a finished result sits in
// the output register while the next frame is taken. The viewport size
// registers are written over APB at byte addresses 0 and 4; a size of 0
// acts as 1. When a denominator would overflow COUNT_BITS, both sequences
// restart and the result carries wrapped.
// ---------------------------------------------------------------------------
module halton_subpixel_jitter_generator #(
	parameter int COUNT_BITS = hspj_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = hspj_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	hspj_stream_if.sink                  req,
	hspj_stream_if.source                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hspj_pkg::APB_AW-1:0]  paddr,
	input  logic [hspj_pkg::APB_DW-1:0]  pwdata,
	output logic [hspj_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import hspj_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] X_LIM   = CNT_MAX / 2;
	localparam logic [COUNT_BITS-1:0] Y_LIM   = CNT_MAX / 3;
	localparam logic [COUNT_BITS-1:0] ONE     = COUNT_BITS'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GAP,
		S_SEARCH,
		S_MUL,
		S_UPDATE,
		S_JIT,
		S_WAIT,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [SIZE_W-1:0]      width_q;
	logic [SIZE_W-1:0]      height_q;
	logic [COUNT_BITS-1:0]  xn_q;
	logic [COUNT_BITS-1:0]  xd_q;
	logic [COUNT_BITS-1:0]  yn_q;
	logic [COUNT_BITS-1:0]  yd_q;
	logic                   out_valid_q;

	logic [COUNT_BITS-1:0]  gx_q;
	logic [COUNT_BITS-1:0]  gy_q;
	logic [COUNT_BITS-1:0]  qx_q;
	logic [COUNT_BITS-1:0]  qy_q;
	logic [COUNT_BITS+1:0]  px_q;
	logic [COUNT_BITS+1:0]  py_q;
	logic                   wrap_q;
	frame_rsp_t             out_q;

	logic                   cfg_wr;
	logic                   in_xfer;
	logic                   out_load;
	logic [COUNT_BITS:0]    nx;
	logic [COUNT_BITS+1:0]  ny;
	logic                   x_step;
	logic                   y_step;
	logic                   ovx;
	logic                   ovy;
	logic [COUNT_BITS+1:0]  x_sub;
	logic [COUNT_BITS+1:0]  y_sub;
	logic [COUNT_BITS+1:0]  yd3;
	logic                   jit_start;
	jit_stat_t              jx_st;
	jit_stat_t              jy_st;
	logic signed [JIT_W-1:0] jx_val;
	logic signed [JIT_W-1:0] jy_val;

	// configuration port
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[REG_IDX_BIT] == REG_VIEWPORT_HEIGHT) ?
		APB_DW'(height_q) : APB_DW'(width_q);

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// search: climb one power of the base per cycle while below gap and den
	assign nx     = {qx_q, 1'b0};
	assign ny     = (COUNT_BITS+2)'({qy_q, 1'b0}) + (COUNT_BITS+2)'(qy_q);
	assign x_step = (gx_q != ONE) && (nx < {1'b0, gx_q}) && (nx < {1'b0, xd_q});
	assign y_step = (gy_q != ONE) && (ny < {2'b00, gy_q}) && (ny < {2'b00, yd_q});

	// update: new numerator (base+1)*q - gap, overflow on denominator growth
	assign x_sub = px_q - (COUNT_BITS+2)'(gx_q);
	assign y_sub = py_q - (COUNT_BITS+2)'(gy_q);
	assign ovx   = (gx_q == ONE) && (xd_q > X_LIM);
	assign ovy   = (gy_q == ONE) && (yd_q > Y_LIM);

	// base 3 denominator growth when the gap is one
	assign yd3   = (COUNT_BITS+2)'({yd_q, 1'b0}) + (COUNT_BITS+2)'(yd_q);

	assign jit_start = (state_q == S_JIT);

	// sequencer, sequence state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= SIZE_W'(1);
			height_q    <= SIZE_W'(1);
			xn_q        <= '0;
			xd_q        <= ONE;
			yn_q        <= '0;
			yd_q        <= ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[REG_IDX_BIT] == REG_VIEWPORT_WIDTH) begin
					width_q <= pwdata[SIZE_W-1:0];
				end else begin
					height_q <= pwdata[SIZE_W-1:0];
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (req.data.restart) begin
							xn_q <= '0;
							xd_q <= ONE;
							yn_q <= '0;
							yd_q <= ONE;
						end
						state_q <= S_GAP;
					end
				end
				S_GAP: begin
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (!x_step && !y_step) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (ovx || ovy) begin
						// restart both and take the first sample
						xn_q <= ONE;
						xd_q <= COUNT_BITS'(2);
						yn_q <= ONE;
						yd_q <= COUNT_BITS'(3);
					end else begin
						if (gx_q == ONE) begin
							xn_q <= ONE;
							xd_q <= {xd_q[COUNT_BITS-2:0], 1'b0};
						end else begin
							xn_q <= x_sub[COUNT_BITS-1:0];
						end
						if (gy_q == ONE) begin
							yn_q <= ONE;
							yd_q <= yd3[COUNT_BITS-1:0];
						end else begin
							yn_q <= y_sub[COUNT_BITS-1:0];
						end
					end
					state_q <= S_JIT;
				end
				S_JIT: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (jx_st.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the update
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_GAP: begin
				gx_q <= xd_q - xn_q;
				gy_q <= yd_q - yn_q;
				qx_q <= ONE;
				qy_q <= ONE;
			end
			S_SEARCH: begin
				if (x_step) begin
					qx_q <= nx[COUNT_BITS-1:0];
				end
				if (y_step) begin
					qy_q <= ny[COUNT_BITS-1:0];
				end
			end
			S_MUL: begin
				// base 2 needs 3q, base 3 needs 4q
				px_q <= (COUNT_BITS+2)'({qx_q, 1'b0}) + (COUNT_BITS+2)'(qx_q);
				py_q <= {qy_q, 2'b00};
			end
			S_UPDATE: begin
				wrap_q <= ovx || ovy;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.x_numerator   <= OUT_W'(xn_q);
			out_q.x_denominator <= OUT_W'(xd_q);
			out_q.y_numerator   <= OUT_W'(yn_q);
			out_q.y_denominator <= OUT_W'(yd_q);
			out_q.jitter_x      <= jx_val;
			out_q.jitter_y      <= jy_val;
			out_q.wrapped       <= wrap_q;
		end
	end

	// jitter units, x over width, y over height
	hspj_jitter #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_jit_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (jit_start),
		.num    (xn_q),
		.den    (xd_q),
		.size   (width_q),
		.stat   (jx_st),
		.jitter (jx_val)
	);

	hspj_jitter #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_jit_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (jit_start),
		.num    (yn_q),
		.den    (yd_q),
		.size   (height_q),
		.stat   (jy_st),
		.jitter (jy_val)
	);

	// both jitter units run in lockstep
	a_jit_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(jx_st.done == jy_st.done) && (jx_st.busy == jy_st.busy))
		else $error("jitter units out of step");

	// the stored fractions stay proper
	a_frac_proper: assert property (@(posedge clk) disable iff (!arst_n)
		(xn_q < xd_q) && (yn_q < yd_q))
		else $error("sequence numerator not below denominator");

	// one frame in flight: no transfer right after a transfer
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !req.ready)
		else $error("frame taken while another is in flight");

	// a wrap always yields the first sample
	a_wrap_first: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.wrapped) |->
		(rsp.data.x_denominator == OUT_W'(2)) && (rsp.data.y_denominator == OUT_W'(3)))
		else $error("wrapped result is not the first sample");

endmodule

// ===== dv/halton_subpixel_jitter_generator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// halton_subpixel_jitter_generator_tb
// Self-checking bench for the Halton (2,3) subpixel jitter generator.
// ---------------------------------------------------------------------------
// Frame ticks go in on the request stream and results are checked field by
// field against a cycle-free model of the two incremental Halton sequences
// and the rounded jitter division. Viewport sizes are changed over APB
// between phases while the block is idle. The phases cover no idling, a
// slow sender, a slow receiver, both slow, and a long receiver hold-off
// that backs the block up into its input.
// ---------------------------------------------------------------------------

// Expected-frame store with its own copy of the sequence state and sizes.
class frame_scoreboard;
	longint unsigned x_num, x_den, y_num, y_den;
	logic [hspj_pkg::SIZE_W-1:0] width_cfg, height_cfg;
	hspj_pkg::frame_rsp_t expected_q[$];
	int errors;
	int frames_seen;

	function new();
		restart_seq();
		width_cfg = 1;
		height_cfg = 1;
		errors = 0;
		frames_seen = 0;
	endfunction

	function void restart_seq();
		x_num = 0;
		x_den = 1;
		y_num = 0;
		y_den = 1;
	endfunction

	function void set_size(logic idx, logic [hspj_pkg::SIZE_W-1:0] value);
		if (idx == hspj_pkg::REG_VIEWPORT_WIDTH)
			width_cfg = value;
		else
			height_cfg = value;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// One incremental Halton step; returns 0 and leaves state alone on overflow.
	function bit advance_seq(inout longint unsigned num, inout longint unsigned den,
			input longint unsigned radix);
		longint unsigned cnt_max;
		longint unsigned gap;
		longint unsigned q;
		cnt_max = (64'd1 << hspj_pkg::COUNT_BITS_DEF) - 1;
		gap = den - num;
		if (gap == 1) begin
			if (den > cnt_max / radix)
				return 1'b0;
			num = 1;
			den = den * radix;
		end else begin
			q = den / radix;
			while (gap <= q && q > 0)
				q = q / radix;
			num = ((radix + 1) * q - gap) & cnt_max;
		end
		return 1'b1;
	endfunction

	// (2*n/d - 1)/size with FRAC_BITS fraction bits, rounded half away from zero.
	function logic [hspj_pkg::JIT_W-1:0] jitter_of(longint unsigned n, longint unsigned d,
			longint unsigned size);
		longint unsigned mag, rem, quo, res;
		bit neg;
		if (d == 0)
			d = 1;
		if (n >= d)
			n = d - 1;
		if (size == 0)
			size = 1;
		if (n >= d - n) begin
			neg = 1'b0;
			mag = n - (d - n);
		end else begin
			neg = 1'b1;
			mag = (d - n) - n;
		end
		// restoring division, one extra bit for rounding
		rem = mag;
		quo = 0;
		for (int i = 0; i <= hspj_pkg::FRAC_BITS_DEF; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= d) begin
				rem = rem - d;
				quo = quo | 1;
			end
		end
		quo = quo / size;
		res = (quo + 1) >> 1;
		if (neg) begin
			if (res > 64'h8000_0000)
				res = 64'h8000_0000;
			return hspj_pkg::JIT_W'(64'd0 - res);
		end
		if (res > 64'h7FFF_FFFF)
			res = 64'h7FFF_FFFF;
		return hspj_pkg::JIT_W'(res);
	endfunction

	// Called on every accepted frame tick.
	function void note_frame(logic restart);
		longint unsigned xn, xd, yn, yd;
		bit ok_x, ok_y;
		hspj_pkg::frame_rsp_t want;
		if (restart)
			restart_seq();
		xn = x_num;
		xd = x_den;
		yn = y_num;
		yd = y_den;
		ok_x = advance_seq(xn, xd, 2);
		ok_y = advance_seq(yn, yd, 3);
		want.wrapped = !(ok_x && ok_y);
		// overflow on either side restarts both and takes the first sample
		if (want.wrapped) begin
			xn = 0;
			xd = 1;
			yn = 0;
			yd = 1;
			void'(advance_seq(xn, xd, 2));
			void'(advance_seq(yn, yd, 3));
		end
		x_num = xn;
		x_den = xd;
		y_num = yn;
		y_den = yd;
		want.x_numerator = hspj_pkg::OUT_W'(xn);
		want.x_denominator = hspj_pkg::OUT_W'(xd);
		want.y_numerator = hspj_pkg::OUT_W'(yn);
		want.y_denominator = hspj_pkg::OUT_W'(yd);
		want.jitter_x = jitter_of(xn, xd, width_cfg);
		want.jitter_y = jitter_of(yn, yd, height_cfg);
		expected_q.push_back(want);
	endfunction

	task report_mismatch(string msg);
		$display("[%0t] MISMATCH frame %0d: %s", $time, frames_seen, msg);
		errors++;
	endtask

	// Called on every accepted result transfer.
	task check_frame(hspj_pkg::frame_rsp_t got);
		hspj_pkg::frame_rsp_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: %h", got));
			frames_seen++;
			return;
		end
		want = expected_q.pop_front();
		if (got.x_numerator !== want.x_numerator)
			report_mismatch($sformatf("x_numerator %0d, want %0d",
				got.x_numerator, want.x_numerator));
		if (got.x_denominator !== want.x_denominator)
			report_mismatch($sformatf("x_denominator %0d, want %0d",
				got.x_denominator, want.x_denominator));
		if (got.y_numerator !== want.y_numerator)
			report_mismatch($sformatf("y_numerator %0d, want %0d",
				got.y_numerator, want.y_numerator));
		if (got.y_denominator !== want.y_denominator)
			report_mismatch($sformatf("y_denominator %0d, want %0d",
				got.y_denominator, want.y_denominator));
		if (got.jitter_x !== want.jitter_x)
			report_mismatch($sformatf("jitter_x %h, want %h", got.jitter_x, want.jitter_x));
		if (got.jitter_y !== want.jitter_y)
			report_mismatch($sformatf("jitter_y %h, want %h", got.jitter_y, want.jitter_y));
		if (got.wrapped !== want.wrapped)
			report_mismatch($sformatf("wrapped %b, want %b", got.wrapped, want.wrapped));
		frames_seen++;
	endtask
endclass

module halton_subpixel_jitter_generator_tb;
	import hspj_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam longint TIMEOUT_NS = 64'd20_000_000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	hspj_stream_if #(.T(frame_req_t)) frame_in ();
	hspj_stream_if #(.T(frame_rsp_t)) frame_out ();

	// knobs of the sender and the receiver
	int send_idle_pct;
	int recv_stall_pct;
	int hold_len;
	int hold_gen;

	frame_scoreboard sb;

	halton_subpixel_jitter_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(frame_in),
		.rsp(frame_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	// APB write: setup cycle, then access until pready
	task automatic apb_write(input logic idx, input logic [SIZE_W-1:0] value);
		logic [APB_DW-1:0] word;
		word = $urandom;
		word[SIZE_W-1:0] = value;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx) << REG_IDX_BIT;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_size(idx, value);
	endtask

	// One frame tick; valid stays up after the transfer for back-to-back items
	task automatic send_frame(input logic restart);
		while ($urandom_range(99) < send_idle_pct) begin
			frame_in.valid <= 1'b0;
			@(posedge clk);
		end
		frame_in.valid <= 1'b1;
		frame_in.data.restart <= restart;
		do @(posedge clk); while (!frame_in.ready);
		sb.note_frame(restart);
	endtask

	// Drop valid, wait for every pending result, then let the block settle
	task automatic wait_drained();
		frame_in.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random frames, mostly long runs of the sequence with a rare restart
	task automatic run_phase(input int idle_pct, input int stall_pct,
			input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
			input int n, input int pause_at);
		apb_write(REG_VIEWPORT_WIDTH, w);
		apb_write(REG_VIEWPORT_HEIGHT, h);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				wait_drained();
			send_frame($urandom_range(39) == 0);
		end
		wait_drained();
	endtask

	// Result side: samples transfers, drives ready, runs the hold-off
	initial begin : result_sink
		int hold_left;
		int hold_ack;
		hold_left = 0;
		hold_ack = 0;
		frame_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (frame_out.valid && frame_out.ready)
				sb.check_frame(frame_out.data);
			if (hold_gen != hold_ack) begin
				hold_ack = hold_gen;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_out.ready <= 1'b0;
			end else begin
				frame_out.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Stimulus
	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 0;
		hold_gen = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_in.valid = 1'b0;
		frame_in.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: first samples from reset, restarts mid-sequence and back to back
		repeat (4) send_frame(1'b0);
		send_frame(1'b1);
		repeat (3) send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b1);
		wait_drained();

		// zero sizes act as one
		apb_write(REG_VIEWPORT_WIDTH, '0);
		apb_write(REG_VIEWPORT_HEIGHT, '0);
		repeat (3) send_frame(1'b0);
		wait_drained();

		// largest nominal sizes
		apb_write(REG_VIEWPORT_WIDTH, SIZE_W'(8192));
		apb_write(REG_VIEWPORT_HEIGHT, SIZE_W'(8192));
		repeat (3) send_frame(1'b0);
		send_frame(1'b1);
		wait_drained();

		// width beyond the nominal range with all register bits set, height one
		apb_write(REG_VIEWPORT_WIDTH, '1);
		apb_write(REG_VIEWPORT_HEIGHT, SIZE_W'(1));
		repeat (4) send_frame(1'b0);
		wait_drained();

		// random phases with the idling mixes
		run_phase(0, 0, SIZE_W'($urandom_range(1, 8192)), SIZE_W'($urandom_range(1, 8192)),
			150, -1);
		run_phase(68, 0, SIZE_W'(1), SIZE_W'(8192), 150, -1);
		run_phase(0, 68, SIZE_W'($urandom_range(1, 8192)), SIZE_W'(1), 150, -1);
		run_phase(19, 19, SIZE_W'($urandom_range(0, 16383)),
			SIZE_W'($urandom_range(1, 8192)), 150, -1);

		// long receiver hold-off backs the block up; sender later waits for a drain
		hold_len = 600;
		hold_gen++;
		run_phase(0, 10, SIZE_W'($urandom_range(1, 64)), SIZE_W'($urandom_range(1, 64)),
			100, 50);

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
